### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

### rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, byte masks, length codes and result type of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int RAW_W  = 32;
  localparam int LANES  = RAW_W / BYTE_W;
  localparam int LANE_W = $clog2(LANES);

  // Lead byte classification masks
  localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] QUAD_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] TRI_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] HIGH_BIT  = 8'h80;

  // Payload masks
  localparam logic [BYTE_W-1:0] PAY2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] PAY3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] PAY4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

  // Sequence length codes
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_TRI  = 3'd3;
  localparam logic [LEN_W-1:0] LEN_QUAD = 3'd4;

  typedef struct packed {
    logic              char_done;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_length;
    logic [RAW_W-1:0]  raw_bytes;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/u8dec_byte_if.sv
// ----------------------------------------------------------------------------
// u8dec_byte_if
// Valid/ready channel carrying one raw stream byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_byte_if import u8dec_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

### rtl/core/u8dec_res_if.sv
// ----------------------------------------------------------------------------
// u8dec_res_if
// Valid/ready channel carrying one decode result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_res_if import u8dec_pkg::*;;
  logic              valid;
  logic              ready;
  logic              char_done;
  logic [CP_W-1:0]   code_point;
  logic [LEN_W-1:0]  seq_length;
  logic [RAW_W-1:0]  raw_bytes;

  modport source (output valid, output char_done, output code_point,
                  output seq_length, output raw_bytes, input ready);
  modport sink   (input valid, input char_done, input code_point,
                  input seq_length, input raw_bytes, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream, one result beat per input byte.
// ----------------------------------------------------------------------------
// Each accepted byte's result is registered into the output or skid register.
// Throughput: one byte per cycle while the skid register is empty; the decode
//   state update is a single registered pass, and a two-entry output stage
//   (result + skid register) keeps input accepting one more beat on a stall.
// Reset (rst, synchronous): decoder returns to idle, output stage empties.
`default_nettype none
`include "assert_macros.svh"

module utf8_byte_stream_decoder import u8dec_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  u8dec_byte_if.sink    byte_ch,
  u8dec_res_if.source   char_ch
);

  // Decode state
  logic              in_seq, in_seq_next;
  logic [LEN_W-1:0]  exp_cnt, exp_cnt_next;
  logic [LEN_W-1:0]  rcv_cnt, rcv_cnt_next;
  logic [BYTE_W-1:0] store [LANES];
  logic [BYTE_W-1:0] store_next [LANES];
  logic [CP_W-1:0]   acc, acc_next;

  // Output stage
  result_t res_next;
  result_t out_q;
  result_t skid_q;
  logic    out_valid;
  logic    skid_valid;

  logic in_fire;
  logic out_fire;

  assign byte_ch.ready = !skid_valid;
  assign in_fire       = byte_ch.valid && byte_ch.ready;
  assign out_fire      = out_valid && char_ch.ready;

  // Single-pass decode of the incoming byte
  always_comb begin
    logic [BYTE_W-1:0] b;
    logic              is_lead;
    logic [BYTE_W-1:0] payload;
    logic [LEN_W-1:0]  base_cnt;
    logic [CP_W-1:0]   base_acc;
    logic              done;

    b        = byte_ch.byte_in;
    is_lead  = (b & LEAD_MASK) == LEAD_MASK;
    base_cnt = rcv_cnt;
    base_acc = acc;
    exp_cnt_next = exp_cnt;
    for (int i = 0; i < LANES; i++) begin
      store_next[i] = store[i];
    end

    // Lead classification and payload extraction
    if (is_lead) begin
      base_cnt = LEN_NONE;
      base_acc = '0;
      if ((b & QUAD_MASK) == QUAD_MASK) begin
        exp_cnt_next = LEN_QUAD;
        payload      = b & PAY4_MASK;
      end else if ((b & TRI_MASK) == TRI_MASK) begin
        exp_cnt_next = LEN_TRI;
        payload      = b & PAY3_MASK;
      end else begin
        exp_cnt_next = LEN_TWO;
        payload      = b & PAY2_MASK;
      end
    end else if (in_seq || ((b & HIGH_BIT) != '0)) begin
      payload = b & CONT_MASK;
    end else begin
      payload = b;
    end

    // Sequence step or standalone one-byte character
    if (is_lead || in_seq) begin
      store_next[base_cnt[LANE_W-1:0]] = b;
      rcv_cnt_next = base_cnt + LEN_W'(1);
      acc_next     = {base_acc[CP_W-7:0], 6'd0} | CP_W'(payload);
      done         = rcv_cnt_next >= exp_cnt_next;
      in_seq_next  = !done;
    end else begin
      exp_cnt_next  = LEN_ONE;
      rcv_cnt_next  = LEN_ONE;
      store_next[0] = b;
      acc_next      = CP_W'(payload);
      done          = 1'b1;
      in_seq_next   = 1'b0;
    end

    // Result beat; lanes not yet received read as zero
    res_next.char_done  = done;
    res_next.code_point = acc_next;
    res_next.seq_length = exp_cnt_next;
    for (int i = 0; i < LANES; i++) begin
      res_next.raw_bytes[BYTE_W*i +: BYTE_W] =
        (LEN_W'(i) < rcv_cnt_next) ? store_next[i] : '0;
    end
  end

  // Decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_seq  <= 1'b0;
      exp_cnt <= LEN_NONE;
      rcv_cnt <= LEN_NONE;
      acc     <= '0;
    end else if (in_fire) begin
      in_seq  <= in_seq_next;
      exp_cnt <= exp_cnt_next;
      rcv_cnt <= rcv_cnt_next;
      acc     <= acc_next;
    end
  end

  // Byte lanes; only lanes below the count are ever shown
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < LANES; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_q <= res_next;
      end else begin
        skid_q <= res_next;
      end
    end
  end

  assign char_ch.valid      = out_valid;
  assign char_ch.char_done  = out_q.char_done;
  assign char_ch.code_point = out_q.code_point;
  assign char_ch.seq_length = out_q.seq_length;
  assign char_ch.raw_bytes  = out_q.raw_bytes;

  // Checks
  `ASSERT_PROP(a_skid_implies_out, clk, rst, skid_valid |-> out_valid)
  `ASSERT_PROP(a_fill_empty_out, clk, rst, (in_fire && !out_valid) |=> out_valid)
  `ASSERT_NEVER(a_seq_count_bound, clk, rst, in_seq && !(rcv_cnt < exp_cnt))
  `ASSERT_NEVER(a_partial_len, clk, rst, out_valid && !out_q.char_done && out_q.seq_length < LEN_TWO)
  `ASSERT_NEVER(a_len_bound, clk, rst, out_valid && out_q.seq_length > LEN_QUAD)

endmodule

`default_nettype wire
